// ===== src/eddp_pkg.sv =====
// Shared constants, request codes and state type for the edit distance block.
`timescale 1ns / 1ps
package eddp_pkg;

    localparam int MAX_LEN_DEF     = 64;
    localparam int SYMBOL_BITS_DEF = 8;

    localparam int REQ_W    = 2;
    localparam int SYM_IN_W = 8;
    localparam int FIELD_W  = 7;
    localparam int OUT_DW   = 24;

    localparam logic [REQ_W-1:0] REQ_FIRST   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SECOND  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_CELL,
        ST_DONE
    } t_state;

endpackage

// ===== src/eddp_ram.sv =====
// Simple dual-port synchronous RAM with registered, enabled read.
`timescale 1ns / 1ps
module eddp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/eddp_cell.sv =====
// One cell of the edit distance recurrence: match or minimum of three plus one.
`timescale 1ns / 1ps
module eddp_cell #(
    parameter int CW = 7,
    parameter int SW = 8
) (
    input  logic [CW-1:0] i_diag,
    input  logic [CW-1:0] i_left,
    input  logic [CW-1:0] i_up,
    input  logic [SW-1:0] i_sym_a,
    input  logic [SW-1:0] i_sym_b,
    output logic [CW-1:0] o_cell
);

    logic [CW-1:0] w_min_lu;
    logic [CW-1:0] w_min3;

    always_comb begin
        w_min_lu = (i_left < i_up) ? i_left : i_up;
        w_min3   = (w_min_lu < i_diag) ? w_min_lu : i_diag;
        o_cell   = (i_sym_a == i_sym_b) ? i_diag : (w_min3 + CW'(1));
    end

endmodule

// ===== src/edit_distance_dp.sv =====
// Top level of the Levenshtein edit distance block.
`timescale 1ns / 1ps
// Usage:
//   Slave channel: tuser carries the request (0 append to first string,
//   1 append to second string, 2 compute), tdata carries the symbol.
//   Append beats are taken one per cycle while the block is idle; an append
//   to a full string is dropped and raises the overflow flag of the next
//   result. Request code 3 is taken and ignored.
//   A compute beat snapshots both lengths, empties both strings and walks
//   the cost matrix one cell per cycle through the cost row RAM, with a row
//   step before each row to fetch the row symbol; when either string is
//   empty it goes straight to the result. tready stays low during that walk.
//   Master channel: one beat per compute, held in an output register until
//   taken; appends are accepted while it waits. A following compute finishes
//   its walk and then waits for the output register to free up.
//   Reset empties both strings, clears the overflow flag and drops any
//   pending result. String contents need no clearing.
module edit_distance_dp #(
    parameter int MAX_LEN     = eddp_pkg::MAX_LEN_DEF,
    parameter int SYMBOL_BITS = eddp_pkg::SYMBOL_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [eddp_pkg::SYM_IN_W-1:0]    i_s_tdata,  // [7:0] symbol
    input  logic [eddp_pkg::REQ_W-1:0]       i_s_tuser,  // [1:0] req_type
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [6:0] distance, [7] overflow, [14:8] first_length,
    // [21:15] second_length, [23:22] zero
    output logic [eddp_pkg::OUT_DW-1:0]      o_m_tdata
);

    import eddp_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int SW = SYMBOL_BITS;
    localparam int EW = (CW > FIELD_W) ? CW : FIELD_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);

    t_state r_state, n_state;

    logic [CW-1:0] r_first_cnt, r_second_cnt;
    logic          r_dropped;
    logic [CW-1:0] r_m, r_n, r_i, r_j;
    logic [CW-1:0] r_diag, r_left, r_dist;
    logic          r_ovf;
    logic          r_out_valid;
    logic [FIELD_W-1:0] r_out_dist, r_out_m, r_out_n;
    logic          r_out_ovf;

    logic          w_in_fire, w_out_free, w_row_end;
    logic [SW-1:0] w_sym;
    logic [SW-1:0] w_sym_a, w_sym_b;
    logic [CW-1:0] w_cost_q, w_up, w_cell, w_jm1;
    logic          w_first_we, w_second_we, w_first_re, w_row_re, w_cost_we;
    logic [AW-1:0] w_row_raddr;
    logic [EW-1:0] w_dist_ext, w_m_ext, w_n_ext;

    for (genvar k = 0; k < SW; k++) begin : g_sym
        if (k < SYM_IN_W) begin : g_bit
            assign w_sym[k] = i_s_tdata[k];
        end else begin : g_zero
            assign w_sym[k] = 1'b0;
        end
    end

    assign w_in_fire  = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_row_end  = (r_j == r_n);
    assign w_jm1      = r_j - CW'(1);
    assign w_up       = (r_i == CW'(1)) ? r_j : w_cost_q;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire && i_s_tuser == REQ_COMPUTE) begin
                    n_state = (r_first_cnt == '0 || r_second_cnt == '0) ? ST_DONE : ST_ROW;
                end
            end
            ST_ROW: begin
                n_state = ST_CELL;
            end
            ST_CELL: begin
                if (w_row_end) begin
                    n_state = (r_i == r_m) ? ST_DONE : ST_ROW;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready  = (r_state == ST_IDLE);
        w_first_we  = 1'b0;
        w_second_we = 1'b0;
        w_first_re  = (r_state == ST_ROW);
        w_row_re    = (r_state == ST_ROW) || (r_state == ST_CELL);
        w_cost_we   = (r_state == ST_CELL);
        w_row_raddr = (r_state == ST_ROW) ? '0 : r_j[AW-1:0];
        if (w_in_fire) begin
            w_first_we  = (i_s_tuser == REQ_FIRST) && (r_first_cnt < MAX_CNT);
            w_second_we = (i_s_tuser == REQ_SECOND) && (r_second_cnt < MAX_CNT);
        end
    end

    function automatic logic [AW-1:0] w_jm1_row_addr(input logic [CW-1:0] idx);
        logic [CW-1:0] dec;
        dec = idx - CW'(1);
        return dec[AW-1:0];
    endfunction

    eddp_ram #(.DEPTH(MAX_LEN), .WIDTH(SW)) u_first_ram (
        .i_clk   (i_clk),
        .i_we    (w_first_we),
        .i_waddr (r_first_cnt[AW-1:0]),
        .i_wdata (w_sym),
        .i_re    (w_first_re),
        .i_raddr (w_jm1_row_addr(r_i)),
        .o_rdata (w_sym_a)
    );

    eddp_ram #(.DEPTH(MAX_LEN), .WIDTH(SW)) u_second_ram (
        .i_clk   (i_clk),
        .i_we    (w_second_we),
        .i_waddr (r_second_cnt[AW-1:0]),
        .i_wdata (w_sym),
        .i_re    (w_row_re),
        .i_raddr (w_row_raddr),
        .o_rdata (w_sym_b)
    );

    eddp_ram #(.DEPTH(MAX_LEN), .WIDTH(CW)) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (w_cost_we),
        .i_waddr (w_jm1[AW-1:0]),
        .i_wdata (w_cell),
        .i_re    (w_row_re),
        .i_raddr (w_row_raddr),
        .o_rdata (w_cost_q)
    );

    eddp_cell #(.CW(CW), .SW(SW)) u_cell (
        .i_diag  (r_diag),
        .i_left  (r_left),
        .i_up    (w_up),
        .i_sym_a (w_sym_a),
        .i_sym_b (w_sym_b),
        .o_cell  (w_cell)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_first_cnt  <= '0;
            r_second_cnt <= '0;
            r_dropped    <= 1'b0;
            r_i          <= '0;
            r_j          <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_fire) begin
                        priority if (i_s_tuser == REQ_FIRST) begin
                            if (r_first_cnt < MAX_CNT) begin
                                r_first_cnt <= r_first_cnt + CW'(1);
                            end else begin
                                r_dropped <= 1'b1;
                            end
                        end else if (i_s_tuser == REQ_SECOND) begin
                            if (r_second_cnt < MAX_CNT) begin
                                r_second_cnt <= r_second_cnt + CW'(1);
                            end else begin
                                r_dropped <= 1'b1;
                            end
                        end else if (i_s_tuser == REQ_COMPUTE) begin
                            r_m          <= r_first_cnt;
                            r_n          <= r_second_cnt;
                            r_ovf        <= r_dropped;
                            r_dist       <= (r_first_cnt == '0) ? r_second_cnt : r_first_cnt;
                            r_i          <= CW'(1);
                            r_first_cnt  <= '0;
                            r_second_cnt <= '0;
                            r_dropped    <= 1'b0;
                        end else begin
                            r_i <= r_i;
                        end
                    end
                end
                ST_ROW: begin
                    r_diag <= r_i - CW'(1);
                    r_left <= r_i;
                    r_j    <= CW'(1);
                end
                ST_CELL: begin
                    r_diag <= w_up;
                    r_left <= w_cell;
                    if (w_row_end) begin
                        r_dist <= w_cell;
                        if (r_i != r_m) begin
                            r_i <= r_i + CW'(1);
                        end
                    end else begin
                        r_j <= r_j + CW'(1);
                    end
                end
                ST_DONE: begin
                    r_j <= r_j;
                end
                default: begin
                    r_j <= r_j;
                end
            endcase
        end
    end

    assign w_dist_ext = EW'(r_dist);
    assign w_m_ext    = EW'(r_m);
    assign w_n_ext    = EW'(r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_out_dist <= w_dist_ext[FIELD_W-1:0];
            r_out_ovf  <= r_ovf;
            r_out_m    <= w_m_ext[FIELD_W-1:0];
            r_out_n    <= w_n_ext[FIELD_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_DW - 3 * FIELD_W - 1)'(0), r_out_n, r_out_m, r_out_ovf, r_out_dist};

    a_cell_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CELL) |-> (r_j >= CW'(1) && r_j <= r_n))
        else $error("column index outside the active row");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROW) |-> (r_i >= CW'(1) && r_i <= r_m))
        else $error("row index outside the first string");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_first_cnt <= MAX_CNT) && (r_second_cnt <= MAX_CNT))
        else $error("string length beyond capacity");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && w_out_free) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished result not presented");

endmodule
